// ===== sv/i2cms_pkg.sv =====
// Package for the I2C master bit sequencer: transaction types, command codes,
// the queued command descriptor and the fixed phase counts.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package i2cms_pkg;

  // Command codes as they arrive in the input transaction.
  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_SEND_ACK = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_t;

  // One input transaction.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       ack_level;
    logic [7:0] line_samples;
  } in_item_t;

  // One bus phase on the result channel.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_is_input;
    logic       hold_delay;
    logic       is_last;
    logic [7:0] read_byte;
    logic       ack_bit;
  } out_item_t;

  localparam int PHASE_W = 5;

  // Classified command, as held in the queue between front and back.
  typedef struct packed {
    cmd_t               cmd;
    logic [PHASE_W-1:0] last_idx;
    logic [7:0]         data_byte;
    logic               ack_level;
    logic [7:0]         line_samples;
  } desc_t;

  // Index of the final phase of each command's run.
  localparam logic [PHASE_W-1:0] LAST_START    = 5'd2;
  localparam logic [PHASE_W-1:0] LAST_STOP     = 5'd1;
  localparam logic [PHASE_W-1:0] LAST_WRITE    = 5'd24;
  localparam logic [PHASE_W-1:0] LAST_READ     = 5'd15;
  localparam logic [PHASE_W-1:0] LAST_SEND_ACK = 5'd3;
  localparam logic [PHASE_W-1:0] LAST_WAIT_ACK = 5'd1;

  // Bit of line_samples that carries the acknowledge level.
  localparam int TOP_BIT = 7;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Delay period after reset, in clock cycles.
  localparam logic [15:0] DELAY_RESET = 16'd500;

endpackage

`default_nettype wire

// ===== sv/i2cms_front.sv =====
// Front end of the I2C master bit sequencer: accepts command transactions,
// classifies them and pushes a descriptor into the command queue.
// Depends on i2cms_pkg.
`default_nettype none

module i2cms_front (
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  i2cms_pkg::in_item_t   in_item,
  input  wire                   q_full,
  output logic                  q_push,
  output i2cms_pkg::desc_t      q_wdata
);
  import i2cms_pkg::*;

  logic accept;
  logic known;

  // The queue alone throttles the input channel.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Classify the command and work out the length of its phase run.
  always_comb begin
    q_wdata              = '0;
    q_wdata.cmd          = cmd_t'(in_item.command);
    q_wdata.data_byte    = in_item.data_byte;
    q_wdata.ack_level    = in_item.ack_level;
    q_wdata.line_samples = in_item.line_samples;
    known                = 1'b1;
    case (in_item.command)
      CMD_START:    q_wdata.last_idx = LAST_START;
      CMD_STOP:     q_wdata.last_idx = LAST_STOP;
      CMD_WRITE:    q_wdata.last_idx = LAST_WRITE;
      CMD_READ:     q_wdata.last_idx = LAST_READ;
      CMD_SEND_ACK: q_wdata.last_idx = LAST_SEND_ACK;
      CMD_WAIT_ACK: q_wdata.last_idx = LAST_WAIT_ACK;
      default: begin
        // Unknown codes are taken and dropped without any phase.
        q_wdata.cmd = CMD_START;
        known       = 1'b0;
      end
    endcase
  end

  // Reset holds the push low whatever the input side does.
  assign q_push = accept && known && rst_n;

endmodule

`default_nettype wire

// ===== sv/i2cms_queue.sv =====
// Short command queue between the front end and the phase generator of the
// I2C master bit sequencer. Depends on i2cms_pkg.
`default_nettype none

module i2cms_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  i2cms_pkg::desc_t   wdata,
  input  wire                pop,
  output i2cms_pkg::desc_t   rdata,
  output logic               full,
  output logic               empty
);
  import i2cms_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Occupancy follows the pushes and pops of this cycle.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Storage for the queued descriptors.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cms_back.sv =====
// Phase generator of the I2C master bit sequencer: takes descriptors from the
// command queue and emits one bus phase per cycle, unless the output stalls,
// through an output register. Depends on i2cms_pkg.
`default_nettype none

module i2cms_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  i2cms_pkg::desc_t     q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output i2cms_pkg::out_item_t out_item
);
  import i2cms_pkg::*;

  logic               active_r;
  desc_t              desc_r;
  logic [PHASE_W-1:0] phase_r;
  logic [1:0]         sub_r;
  logic [7:0]         shift_r;
  logic               out_valid_r;
  out_item_t          out_r;

  out_item_t          phase;
  logic               advance;
  logic               load;

  // A phase moves into the output register when that register is free.
  assign advance = active_r && (!out_valid_r || !out_stall);
  assign load    = !q_empty && (!active_r || (advance && phase.is_last));
  assign q_pop   = load;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Bus levels of the current phase, from the command and the phase count.
  always_comb begin
    phase              = '0;
    phase.is_last      = (phase_r == desc_r.last_idx);
    phase.hold_delay   = 1'b1;
    case (desc_r.cmd)
      CMD_START: begin
        phase.scl_level  = (phase_r != LAST_START);
        phase.sda_level  = (phase_r == '0);
        phase.hold_delay = (phase_r != LAST_START);
      end
      CMD_STOP: begin
        phase.scl_level  = 1'b1;
        phase.sda_level  = (phase_r == LAST_STOP);
        phase.hold_delay = (phase_r != LAST_STOP);
      end
      CMD_WRITE: begin
        // The lead-in phase pulls SDA low, then three phases per bit.
        if (phase_r != '0) begin
          phase.scl_level = (sub_r == 2'd1);
          phase.sda_level = shift_r[7];
        end
      end
      CMD_READ: begin
        phase.scl_level    = !phase_r[0];
        phase.sda_level    = 1'b1;
        phase.sda_is_input = 1'b1;
        phase.read_byte    = phase.is_last ? desc_r.line_samples : 8'd0;
      end
      CMD_SEND_ACK: begin
        phase.scl_level = (phase_r == 5'd2);
        phase.sda_level = (phase_r == '0) ? 1'b0 : desc_r.ack_level;
      end
      CMD_WAIT_ACK: begin
        phase.scl_level    = (phase_r == '0);
        phase.sda_level    = 1'b1;
        phase.sda_is_input = 1'b1;
        phase.ack_bit      = phase.is_last && desc_r.line_samples[TOP_BIT];
      end
      default: begin
        phase = '0;
      end
    endcase
  end

  // Sequencer control: busy flag and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
      end else if (advance && phase.is_last) begin
        active_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Descriptor, phase counters, data shifter and output payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= phase;
    end
    if (load) begin
      desc_r  <= q_rdata;
      phase_r <= '0;
      sub_r   <= 2'd0;
      shift_r <= q_rdata.data_byte;
    end else if (advance) begin
      phase_r <= phase_r + PHASE_W'(1);
      if (phase_r != '0) begin
        if (sub_r == 2'd2) begin
          sub_r   <= 2'd0;
          shift_r <= {shift_r[6:0], 1'b0};
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer_top.sv =====
// Top level of the I2C master bit sequencer: front end, command queue and
// phase generator, plus the delay period register. Depends on i2cms_pkg,
// i2cms_front, i2cms_queue and i2cms_back.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall   in_item   (i2cms_pkg::in_item_t)
//   out_     output     out_valid / out_stall out_item  (i2cms_pkg::out_item_t)
//   cfg_     input      cfg_wr_en             cfg_wr_data (delay_ticks)
//
// The generator emits one phase per cycle unless the result channel stalls;
// phases per command: 3 start, 2 stop, 25 write, 16 read, 4 send ack, 2 wait
// ack. From an idle generator, a command's first phase is registered in the
// queue, the descriptor register and the output register, in that order.
// A two-entry command queue lets new commands be taken while phases drain.
// Reset is synchronous and active low; it empties the queue and the output.
// A stall on the result channel holds the output register and then the queue.
`default_nettype none

module i2c_master_bit_sequencer_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  i2cms_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output i2cms_pkg::out_item_t out_item,
  input  wire                  cfg_wr_en,
  input  wire [15:0]           cfg_wr_data
);
  import i2cms_pkg::*;

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  desc_t       q_wdata;
  desc_t       q_rdata;
  logic [15:0] delay_ticks_r;

  // Delay period register; it sets the bus timing, not the phase contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      delay_ticks_r <= cfg_wr_data;
    end
  end

  i2cms_front u_front (
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  i2cms_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // The generator never takes a descriptor from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // A configuration write lands in the delay register on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (delay_ticks_r == $past(cfg_wr_data)))
    else $error("delay period register missed a write");

endmodule

`default_nettype wire
